// ===== rtl/core/sfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

  // Field widths fixed by the item formats.
  localparam int CMD_W   = 2;
  localparam int POS_W   = 32;
  localparam int UNIT_W  = 16;
  localparam int IDX_W   = 7;
  // Point differences need one extra bit; one more keeps the magnitude safe.
  localparam int WIDE_W  = POS_W + 2;

  // Default depth of a strand in frames.
  localparam int MAX_FRAMES_DEF = 128;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ROOT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POSE = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] x;
    logic signed [WIDE_W-1:0] y;
    logic signed [WIDE_W-1:0] z;
  } wide_vec_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] x;
    logic signed [UNIT_W-1:0] y;
    logic signed [UNIT_W-1:0] z;
  } unit_vec_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic signed [POS_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         frame_index;
    logic signed [UNIT_W-1:0] aim_x;
    logic signed [UNIT_W-1:0] aim_y;
    logic signed [UNIT_W-1:0] aim_z;
    logic signed [UNIT_W-1:0] up_x;
    logic signed [UNIT_W-1:0] up_y;
    logic signed [UNIT_W-1:0] up_z;
    logic signed [UNIT_W-1:0] side_x;
    logic signed [UNIT_W-1:0] side_y;
    logic signed [UNIT_W-1:0] side_z;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/strand_frame_propagation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Builds aim, up and side unit vectors along a strand from a stream of points.
// A root point, an ignored point and the first pose point of a strand are taken
// without building a frame. A frame takes three normalizations and one or two cross
// products, and may also wait for the output register. Each normalization shifts
// the vector into range, forms the sum of squares, takes a bit-serial square root
// and runs three bit-serial dividers; a zero vector skips these steps and yields
// a zero unit vector. Each cross product is formed on one 16 x 16 multiplier.
// One item is worked on at a time; a finished frame waits in the output register
// while the next item is taken.
module strand_frame_propagation #(
  parameter int MAX_FRAMES = sfp_pkg::MAX_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfp_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfp_pkg::out_item_t out_data
);
  import sfp_pkg::*;

  localparam int FRAME_LIMIT_INT = (MAX_FRAMES - 1 > 127) ? 127 : MAX_FRAMES - 1;
  localparam logic [IDX_W-1:0] FRAME_LIMIT = IDX_W'(FRAME_LIMIT_INT);

  typedef enum logic [2:0] {
    S_IDLE, S_AIM, S_UP0, S_CROSS_A, S_SIDE, S_CROSS_B, S_UP, S_EMIT
  } state_t;

  state_t state;
  point_t    rest_root;
  point_t    prev_point;
  point_t    pt;
  unit_vec_t carried_up;
  logic      have_prev;
  logic [IDX_W-1:0] frame_count;
  logic      is_rest;
  unit_vec_t aim_r;
  unit_vec_t up_r;
  unit_vec_t side_r;
  logic      norm_start;
  wide_vec_t norm_vec;
  logic      norm_done;
  unit_vec_t norm_unit;
  logic [2:0] xs;
  logic signed [2*UNIT_W-1:0] prod;
  wide_vec_t cacc;

  point_t    in_point;
  unit_vec_t xa;
  unit_vec_t xb;
  logic signed [UNIT_W-1:0] ma;
  logic signed [UNIT_W-1:0] mb;
  logic signed [2*UNIT_W-1:0] mres;
  logic signed [WIDE_W-1:0] prod_ext;

  function automatic wide_vec_t point_diff(point_t a, point_t b);
    wide_vec_t d;
    d.x = WIDE_W'(a.x) - WIDE_W'(b.x);
    d.y = WIDE_W'(a.y) - WIDE_W'(b.y);
    d.z = WIDE_W'(a.z) - WIDE_W'(b.z);
    return d;
  endfunction

  // Starting up direction from component differences of the aim.
  function automatic wide_vec_t up_seed(unit_vec_t a);
    wide_vec_t d;
    d.x = WIDE_W'(a.z) - WIDE_W'(a.y);
    d.y = WIDE_W'(a.x) - WIDE_W'(a.z);
    d.z = WIDE_W'(a.y) - WIDE_W'(a.x);
    return d;
  endfunction

  sfp_normalize u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vec   (norm_vec),
    .done  (norm_done),
    .unit  (norm_unit)
  );

  assign in_ready   = (state == S_IDLE);
  assign in_point.x = in_data.point_x;
  assign in_point.y = in_data.point_y;
  assign in_point.z = in_data.point_z;

  // Cross product operands and the multiplier step selection.
  always_comb begin
    xa = (state == S_CROSS_B) ? side_r : aim_r;
    if (state == S_CROSS_B) begin
      xb = aim_r;
    end else begin
      xb = is_rest ? up_r : carried_up;
    end
    case (xs)
      3'd0:    begin ma = xa.y; mb = xb.z; end
      3'd1:    begin ma = xa.z; mb = xb.y; end
      3'd2:    begin ma = xa.z; mb = xb.x; end
      3'd3:    begin ma = xa.x; mb = xb.z; end
      3'd4:    begin ma = xa.x; mb = xb.y; end
      3'd5:    begin ma = xa.y; mb = xb.x; end
      default: begin ma = '0;   mb = '0;   end
    endcase
    mres     = ma * mb;
    prod_ext = WIDE_W'(prod);
  end

  // Frame sequencer, strand state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      norm_start  <= 1'b0;
      have_prev   <= 1'b0;
      frame_count <= '0;
      rest_root   <= '0;
      prev_point  <= '0;
      carried_up  <= '0;
    end else begin
      norm_start <= 1'b0;
      // A frame leaving while the next one is loaded keeps valid high.
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pt <= in_point;
            unique case (in_data.command)
              CMD_ROOT: rest_root <= in_point;
              CMD_REST: begin
                is_rest    <= 1'b1;
                norm_vec   <= point_diff(in_point, rest_root);
                norm_start <= 1'b1;
                state      <= S_AIM;
              end
              CMD_POSE: begin
                if (!have_prev) begin
                  prev_point <= in_point;
                  have_prev  <= 1'b1;
                end else begin
                  is_rest    <= 1'b0;
                  norm_vec   <= point_diff(in_point, prev_point);
                  norm_start <= 1'b1;
                  state      <= S_AIM;
                end
              end
              default: ;
            endcase
          end
        end
        S_AIM: begin
          if (norm_done) begin
            aim_r <= norm_unit;
            xs    <= '0;
            if (is_rest) begin
              norm_vec   <= up_seed(norm_unit);
              norm_start <= 1'b1;
              state      <= S_UP0;
            end else begin
              state <= S_CROSS_A;
            end
          end
        end
        S_UP0: begin
          if (norm_done) begin
            up_r  <= norm_unit;
            xs    <= '0;
            state <= S_CROSS_A;
          end
        end
        S_CROSS_A, S_CROSS_B: begin
          // One product a cycle; the previous product is folded in behind it.
          prod <= mres;
          xs   <= xs + 3'd1;
          case (xs)
            3'd1: cacc.x <= prod_ext;
            3'd2: cacc.x <= cacc.x - prod_ext;
            3'd3: cacc.y <= prod_ext;
            3'd4: cacc.y <= cacc.y - prod_ext;
            3'd5: cacc.z <= prod_ext;
            3'd6: begin
              norm_vec   <= {cacc.x, cacc.y, WIDE_W'(cacc.z - prod_ext)};
              norm_start <= 1'b1;
              state      <= (state == S_CROSS_A) ? S_SIDE : S_UP;
            end
            default: ;
          endcase
        end
        S_SIDE: begin
          if (norm_done) begin
            side_r <= norm_unit;
            xs     <= '0;
            state  <= is_rest ? S_EMIT : S_CROSS_B;
          end
        end
        S_UP: begin
          if (norm_done) begin
            up_r  <= norm_unit;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_data.frame_index <= is_rest ? '0 : frame_count;
            out_data.aim_x  <= aim_r.x;
            out_data.aim_y  <= aim_r.y;
            out_data.aim_z  <= aim_r.z;
            out_data.up_x   <= up_r.x;
            out_data.up_y   <= up_r.y;
            out_data.up_z   <= up_r.z;
            out_data.side_x <= side_r.x;
            out_data.side_y <= side_r.y;
            out_data.side_z <= side_r.z;
            out_valid  <= 1'b1;
            carried_up <= up_r;
            if (is_rest) begin
              have_prev   <= 1'b0;
              frame_count <= IDX_W'(1);
            end else begin
              prev_point <= pt;
              if (frame_count < FRAME_LIMIT) begin
                frame_count <= frame_count + IDX_W'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The normalizer only finishes while the sequencer waits on it.
  a_norm_done_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !norm_done)
    else $error("normalizer finished while the sequencer was idle");

  // The frame index never passes its limit.
  a_frame_limit: assert property (@(posedge clk) disable iff (rst)
    frame_count <= FRAME_LIMIT)
    else $error("frame count beyond its limit");

  // A rest point transfer always starts the aim normalization.
  a_rest_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.command == CMD_REST) |=> (state == S_AIM && norm_start))
    else $error("rest point did not start a frame");

endmodule

`default_nettype wire

// ===== rtl/core/sfp_normalize.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfp_normalize (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sfp_pkg::wide_vec_t vec,
  output logic              done,
  output sfp_pkg::unit_vec_t unit
);
  import sfp_pkg::*;

  localparam int MAG_W  = WIDE_W;
  localparam int SQ_W   = 60;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int REM_W  = 34;
  localparam int QUO_W  = 15;
  localparam int NUM_W  = 45;
  localparam logic [QUO_W-1:0] UNIT_ONE = 15'd16384;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQUARE, N_ROOT, N_PREP, N_DIVIDE, N_FINISH
  } nstate_t;

  nstate_t state;
  logic [MAG_W-1:0]  mag [3];
  logic [2:0]        neg;
  logic [4:0]        cnt;
  logic [SQ_W-1:0]   prod;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_sh;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] drem [3];
  logic [QUO_W-1:0]  quo [3];

  logic signed [MAG_W-1:0] vin [3];
  logic [MAG_W-1:0]  abs_in [3];
  logic [MAG_W-1:0]  big;
  logic [29:0]       sq_op;
  logic [REM_W+1:0]  rs;
  logic [REM_W+1:0]  trial;
  logic [NUM_W-1:0]  num [3];
  logic [ROOT_W:0]   r2 [3];
  logic [ROOT_W:0]   r2_diff [3];
  logic [2:0]        dge;

  // Signed component with the quotient capped at one.
  function automatic logic signed [UNIT_W-1:0] signed_unit(logic [QUO_W-1:0] q, logic n);
    logic [QUO_W-1:0] qc;
    qc = (q > UNIT_ONE) ? UNIT_ONE : q;
    return n ? -signed'({1'b0, qc}) : signed'({1'b0, qc});
  endfunction

  // Magnitudes, largest magnitude and the per-step datapath terms.
  always_comb begin
    vin[0] = vec.x;
    vin[1] = vec.y;
    vin[2] = vec.z;
    for (int k = 0; k < 3; k++) begin
      abs_in[k] = vin[k][MAG_W-1] ? MAG_W'(-vin[k]) : MAG_W'(vin[k]);
    end
    big = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > big) begin
      big = mag[2];
    end
    case (cnt[1:0])
      2'd0:    sq_op = mag[0][29:0];
      2'd1:    sq_op = mag[1][29:0];
      2'd2:    sq_op = mag[2][29:0];
      default: sq_op = '0;
    endcase
    rs    = {rem, sum_sh[SUM_W-1:SUM_W-2]};
    trial = {3'b000, root, 2'b01};
    for (int k = 0; k < 3; k++) begin
      num[k]     = {1'b0, mag[k][29:0], 14'd0} + NUM_W'(root[ROOT_W-1:1]);
      r2[k]      = {drem[k], quo[k][QUO_W-1]};
      r2_diff[k] = r2[k] - {1'b0, root};
      dge[k]     = (r2[k] >= {1'b0, root});
    end
  end

  // Sequencer: shift into range, sum of squares, bit-serial root, bit-serial divides.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int k = 0; k < 3; k++) begin
              mag[k] <= abs_in[k];
              neg[k] <= vin[k][MAG_W-1];
            end
            if (abs_in[0] == '0 && abs_in[1] == '0 && abs_in[2] == '0) begin
              unit <= '0;
              done <= 1'b1;
            end else begin
              state <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (|big[MAG_W-1:30]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else if (!big[29]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            cnt   <= '0;
            sum   <= '0;
            state <= N_SQUARE;
          end
        end
        N_SQUARE: begin
          prod <= sq_op * sq_op;
          if (cnt != 5'd0) begin
            sum <= sum + SUM_W'(prod);
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            sum_sh <= sum + SUM_W'(prod);
            rem    <= '0;
            root   <= '0;
            cnt    <= '0;
            state  <= N_ROOT;
          end
        end
        N_ROOT: begin
          sum_sh <= sum_sh << 2;
          if (rs >= trial) begin
            rem  <= REM_W'(rs - trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rs[REM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            state <= N_PREP;
          end
        end
        N_PREP: begin
          // The quotient stays below 2^15, so the upper bits already sit below the divisor.
          for (int k = 0; k < 3; k++) begin
            drem[k] <= {1'b0, num[k][NUM_W-1:QUO_W]};
            quo[k]  <= num[k][QUO_W-1:0];
          end
          cnt   <= '0;
          state <= N_DIVIDE;
        end
        N_DIVIDE: begin
          for (int k = 0; k < 3; k++) begin
            drem[k] <= dge[k] ? r2_diff[k][ROOT_W-1:0] : r2[k][ROOT_W-1:0];
            quo[k]  <= {quo[k][QUO_W-2:0], dge[k]};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd14) begin
            state <= N_FINISH;
          end
        end
        N_FINISH: begin
          unit.x <= signed_unit(quo[0], neg[0]);
          unit.y <= signed_unit(quo[1], neg[1]);
          unit.z <= signed_unit(quo[2], neg[2]);
          done   <= 1'b1;
          state  <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
